FILE: hw/rtl/itpa_pkg.sv
// Shared types, constants and helpers of the integer-to-ASCII field formatter.
// Used by itpa_digit_unit and integer_to_padded_ascii_unit; no dependencies.
`timescale 1ns / 1ps

package itpa_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_VALUE_BITS = 32;

  // Field widths of the streaming ports
  localparam int CMD_W    = 3;
  localparam int WIDTH_W  = 7;
  localparam int CHAR_W   = 8;
  localparam int IN_TDATA_W = 48;
  localparam int DIGIT_W  = 4;

  // Conversion commands
  localparam logic [CMD_W-1:0] CMD_BIN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SDEC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OCT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UDEC = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HEXL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HEXU = 3'd5;

  // ceil(2^35 / 10): (v * RECIP10) >> 35 is v / 10 for any 32-bit v
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [DIGIT_W-1:0] DEC_BASE   = 4'd10;

  typedef enum logic [1:0] {
    RADIX_2,
    RADIX_8,
    RADIX_10,
    RADIX_16
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_PLAN,
    ST_EMIT
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dz;
    begin
      dz = {4'b0, d};
      if (d < DEC_BASE) begin
        digit_char = ASCII_ZERO + dz;
      end else if (upper) begin
        digit_char = ASCII_UPPER + dz - {4'b0, DEC_BASE};
      end else begin
        digit_char = ASCII_LOWER + dz - {4'b0, DEC_BASE};
      end
    end
  endfunction

endpackage

FILE: hw/rtl/itpa_digit_unit.sv
// Shared digit unit: splits a value into quotient and low digit for the radix.
// Decimal uses a registered reciprocal product; depends on itpa_pkg.
`timescale 1ns / 1ps

module itpa_digit_unit #(
  parameter int VALUE_BITS = itpa_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic [VALUE_BITS-1:0]          value,
  input  itpa_pkg::radix_t               radix,
  output logic [VALUE_BITS-1:0]          quot,
  output logic [itpa_pkg::DIGIT_W-1:0]   rem
);

  logic [63:0]                   prod_r;
  logic [VALUE_BITS-1:0]         q_dec;
  logic [itpa_pkg::DIGIT_W-1:0]  q10_lo;
  logic [1:0]                    shamt;
  logic [itpa_pkg::DIGIT_W-1:0]  mask;

  // Registered product of the current value; valid in the cycle after the value settles
  always_ff @(posedge clk) begin
    prod_r <= {32'b0, 32'(value)} * {32'b0, itpa_pkg::RECIP10};
  end

  assign q_dec  = VALUE_BITS'(prod_r[63:itpa_pkg::RECIP_SHIFT]);
  // Low nibble of q*10 is all the remainder needs
  assign q10_lo = 4'({q_dec[0], 3'b0} + {q_dec[2:0], 1'b0});

  always_comb begin
    case (radix)
      itpa_pkg::RADIX_2: begin
        shamt = 2'd1;
        mask  = 4'h1;
      end
      itpa_pkg::RADIX_8: begin
        shamt = 2'd3;
        mask  = 4'h7;
      end
      default: begin
        shamt = 2'd0;
        mask  = 4'hF;
      end
    endcase
    if (radix == itpa_pkg::RADIX_10) begin
      quot = q_dec;
      rem  = value[3:0] - q10_lo;
    end else if (radix == itpa_pkg::RADIX_16) begin
      quot = value >> 4;
      rem  = value[3:0];
    end else begin
      quot = value >> shamt;
      rem  = value[3:0] & mask;
    end
  end

endmodule

FILE: hw/rtl/integer_to_padded_ascii_unit.sv
// Top level of the integer-to-ASCII field formatter: sequencer, digit store, output beat.
// Depends on itpa_pkg and itpa_digit_unit.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: command; tdata: value, width, flags
//  out_    | out | out_tvalid/tready  | tdata: character; tlast: final character
//
// Per item: accept, then the digits (each decimal digit passes ST_MUL, the reciprocal
// multiplier, then ST_DIV; binary/octal/hex digits only ST_DIV), then plan, then emit.
// Reset (rst_n low, synchronous) returns to idle and drops any pending beat.
// A stalled out_tready holds the character sequencer; in_tready is high only when idle.
// Commands six and seven are taken and produce no beat.
`timescale 1ns / 1ps

module integer_to_padded_ascii_unit #(
  parameter int MAX_WIDTH  = itpa_pkg::DEF_MAX_WIDTH,
  parameter int VALUE_BITS = itpa_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] value, [38:32] width, [39] left_adjust, [40] zero_pad, [47:41] zero
  input  logic [itpa_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [2:0] command
  input  logic [itpa_pkg::CMD_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] character
  output logic [itpa_pkg::CHAR_W-1:0]         out_tdata,
  output logic                                out_tlast
);

  localparam int IDXW = $clog2(VALUE_BITS);
  localparam int CNTW = $clog2(VALUE_BITS + 1);
  localparam int WW   = itpa_pkg::WIDTH_W;

  itpa_pkg::state_t state_r, state_nxt;
  itpa_pkg::radix_t radix_r, radix_nxt;

  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  upper_r, upper_nxt;
  logic                  neg_r, neg_nxt;
  logic                  ladj_r, ladj_nxt;
  logic                  zpad_r, zpad_nxt;
  logic [WW-1:0]         wsat_r, wsat_nxt;
  logic [CNTW-1:0]       nd_r, nd_nxt;
  logic [WW-1:0]         len_r, len_nxt;
  logic [WW-1:0]         actual_r, actual_nxt;
  logic [WW-1:0]         pad_r, pad_nxt;
  logic [WW-1:0]         k_r, k_nxt;
  logic [IDXW-1:0]       dptr_r, dptr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [itpa_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [itpa_pkg::DIGIT_W-1:0] dig_mem [VALUE_BITS];
  logic                         dig_we;

  logic [VALUE_BITS-1:0]        du_quot;
  logic [itpa_pkg::DIGIT_W-1:0] du_rem;

  logic                  in_acc;
  logic [VALUE_BITS-1:0] in_val;
  logic [WW-1:0]         in_width;
  logic [WW-1:0]         sgn;
  logic [WW-1:0]         plan_actual;
  logic [WW-1:0]         plan_len;
  logic                  emit_go;
  logic                  is_dig;
  logic [itpa_pkg::CHAR_W-1:0] ch;

  itpa_digit_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digit (
    .clk   (clk),
    .value (value_r),
    .radix (radix_r),
    .quot  (du_quot),
    .rem   (du_rem)
  );

  assign in_tready  = (state_r == itpa_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_val     = in_tdata[VALUE_BITS-1:0];
  assign in_width   = in_tdata[38:32];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  assign sgn         = {{(WW-1){1'b0}}, neg_r};
  assign plan_actual = WW'(nd_r) + sgn;
  assign plan_len    = (wsat_r > plan_actual) ? wsat_r : plan_actual;
  assign emit_go     = !out_valid_r || out_tready;

  // Character at position k of the field
  always_comb begin
    is_dig = 1'b0;
    ch     = itpa_pkg::ASCII_SPACE;
    if (ladj_r) begin
      if (k_r < sgn) begin
        ch = itpa_pkg::ASCII_MINUS;
      end else if (k_r < actual_r) begin
        is_dig = 1'b1;
      end
    end else if (zpad_r) begin
      if (k_r < sgn) begin
        ch = itpa_pkg::ASCII_MINUS;
      end else if (k_r < sgn + pad_r) begin
        ch = itpa_pkg::ASCII_ZERO;
      end else begin
        is_dig = 1'b1;
      end
    end else begin
      if (k_r < pad_r) begin
        ch = itpa_pkg::ASCII_SPACE;
      end else if (k_r < pad_r + sgn) begin
        ch = itpa_pkg::ASCII_MINUS;
      end else begin
        is_dig = 1'b1;
      end
    end
    if (is_dig) begin
      ch = itpa_pkg::digit_char(dig_mem[dptr_r], upper_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = radix_r;
    value_nxt     = value_r;
    upper_nxt     = upper_r;
    neg_nxt       = neg_r;
    ladj_nxt      = ladj_r;
    zpad_nxt      = zpad_r;
    wsat_nxt      = wsat_r;
    nd_nxt        = nd_r;
    len_nxt       = len_r;
    actual_nxt    = actual_r;
    pad_nxt       = pad_r;
    k_nxt         = k_r;
    dptr_nxt      = dptr_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    dig_we        = 1'b0;

    // Drop the beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      itpa_pkg::ST_IDLE: begin
        if (in_acc) begin
          value_nxt = in_val;
          upper_nxt = 1'b0;
          neg_nxt   = 1'b0;
          ladj_nxt  = in_tdata[39];
          zpad_nxt  = in_tdata[40];
          wsat_nxt  = (in_width > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : in_width;
          nd_nxt    = '0;
          state_nxt = itpa_pkg::ST_DIV;
          case (in_tuser)
            itpa_pkg::CMD_BIN: begin
              radix_nxt = itpa_pkg::RADIX_2;
            end
            itpa_pkg::CMD_SDEC: begin
              radix_nxt = itpa_pkg::RADIX_10;
              state_nxt = itpa_pkg::ST_MUL;
              if (in_val[VALUE_BITS-1]) begin
                neg_nxt   = 1'b1;
                value_nxt = ~in_val + 1'b1;
              end
            end
            itpa_pkg::CMD_OCT: begin
              radix_nxt = itpa_pkg::RADIX_8;
            end
            itpa_pkg::CMD_UDEC: begin
              radix_nxt = itpa_pkg::RADIX_10;
              state_nxt = itpa_pkg::ST_MUL;
            end
            itpa_pkg::CMD_HEXL: begin
              radix_nxt = itpa_pkg::RADIX_16;
            end
            itpa_pkg::CMD_HEXU: begin
              radix_nxt = itpa_pkg::RADIX_16;
              upper_nxt = 1'b1;
            end
            default: begin
              state_nxt = itpa_pkg::ST_IDLE;
            end
          endcase
        end
      end
      itpa_pkg::ST_MUL: begin
        state_nxt = itpa_pkg::ST_DIV;
      end
      itpa_pkg::ST_DIV: begin
        dig_we    = 1'b1;
        value_nxt = du_quot;
        nd_nxt    = nd_r + 1'b1;
        if (du_quot == '0) begin
          state_nxt = itpa_pkg::ST_PLAN;
        end else if (radix_r == itpa_pkg::RADIX_10) begin
          state_nxt = itpa_pkg::ST_MUL;
        end else begin
          state_nxt = itpa_pkg::ST_DIV;
        end
      end
      itpa_pkg::ST_PLAN: begin
        actual_nxt = plan_actual;
        len_nxt    = plan_len;
        pad_nxt    = plan_len - plan_actual;
        k_nxt      = '0;
        dptr_nxt   = IDXW'(nd_r - 1'b1);
        state_nxt  = itpa_pkg::ST_EMIT;
      end
      itpa_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ch;
          out_last_nxt  = (k_r == len_r - 1'b1);
          k_nxt         = k_r + 1'b1;
          if (is_dig) begin
            dptr_nxt = dptr_r - 1'b1;
          end
          if (k_r == len_r - 1'b1) begin
            state_nxt = itpa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itpa_pkg::ST_IDLE;
      nd_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nd_r        <= nd_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r    <= radix_nxt;
    value_r    <= value_nxt;
    upper_r    <= upper_nxt;
    neg_r      <= neg_nxt;
    ladj_r     <= ladj_nxt;
    zpad_r     <= zpad_nxt;
    wsat_r     <= wsat_nxt;
    len_r      <= len_nxt;
    actual_r   <= actual_nxt;
    pad_r      <= pad_nxt;
    dptr_r     <= dptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit store, least significant digit at index zero
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[nd_r[IDXW-1:0]] <= du_rem;
    end
  end

  a_nd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r <= CNTW'(VALUE_BITS))
    else $error("digit count exceeds the value width");

  a_emit_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itpa_pkg::ST_EMIT) |-> (k_r < len_r))
    else $error("character position beyond field length");

  a_len_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itpa_pkg::ST_EMIT) |-> (len_r >= actual_r && len_r <= WW'(MAX_WIDTH + 33)))
    else $error("field length shorter than digits and sign");

  a_legal_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser <= itpa_pkg::CMD_HEXU) |=> (state_r != itpa_pkg::ST_IDLE))
    else $error("legal command did not start a conversion");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itpa_pkg::ST_EMIT && emit_go && k_r == len_r - 1'b1)
      |=> (state_r == itpa_pkg::ST_IDLE && out_tlast && out_tvalid))
    else $error("final character not marked or sequencer did not return to idle");

endmodule

FILE: dv/integer_to_padded_ascii_unit_tb.sv
// Self-checking bench for integer_to_padded_ascii_unit: printf-style integer fields.
// Depends on itpa_pkg and the RTL; a scoreboard class predicts each character beat.
`timescale 1ns / 1ps

module integer_to_padded_ascii_unit_tb;

  localparam int FIELD_MAX  = itpa_pkg::DEF_MAX_WIDTH;
  localparam int LONG_HOLD  = 400;
  localparam int RAND_ITEMS = 440;
  localparam int QUIET_TAIL = 60;

  typedef struct packed {
    logic [itpa_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } field_char_t;

  class char_scoreboard;
    field_char_t expected_chars[$];
    int errors;
    int fields;
    int dropped;
    int chars_seen;

    function new();
      errors     = 0;
      fields     = 0;
      dropped    = 0;
      chars_seen = 0;
    endfunction

    // Format one accepted item and queue the characters it must produce.
    function void note_item(input logic [itpa_pkg::CMD_W-1:0] cmd, input logic [31:0] value,
                            input logic [itpa_pkg::WIDTH_W-1:0] width, input logic ladj,
                            input logic zpad);
      logic [31:0]                 mag;
      logic [itpa_pkg::CHAR_W-1:0] digits[$];
      logic [itpa_pkg::CHAR_W-1:0] text[$];
      logic [itpa_pkg::CHAR_W-1:0] pad_ch;
      int unsigned                 radix;
      int unsigned                 d;
      bit                          upper;
      bit                          neg;
      int                          field_w;
      int                          pad;
      int                          i;
      field_char_t                 fc;

      upper = 1'b0;
      neg   = 1'b0;
      case (cmd)
        itpa_pkg::CMD_BIN:  radix = 2;
        itpa_pkg::CMD_SDEC: radix = 10;
        itpa_pkg::CMD_OCT:  radix = 8;
        itpa_pkg::CMD_UDEC: radix = 10;
        itpa_pkg::CMD_HEXL: radix = 16;
        itpa_pkg::CMD_HEXU: begin
          radix = 16;
          upper = 1'b1;
        end
        default: begin
          dropped++;
          return;
        end
      endcase
      fields++;

      mag = value;
      // most negative value negates to itself, which is the right magnitude unsigned
      if (cmd == itpa_pkg::CMD_SDEC && value[31]) begin
        neg = 1'b1;
        mag = -value;
      end

      do begin
        d = mag % radix;
        if (d < 10) begin
          digits.push_front(itpa_pkg::ASCII_ZERO + itpa_pkg::CHAR_W'(d));
        end else if (upper) begin
          digits.push_front(itpa_pkg::ASCII_UPPER + itpa_pkg::CHAR_W'(d - 10));
        end else begin
          digits.push_front(itpa_pkg::ASCII_LOWER + itpa_pkg::CHAR_W'(d - 10));
        end
        mag = mag / radix;
      end while (mag != 0);

      field_w = (int'(width) > FIELD_MAX) ? FIELD_MAX : int'(width);
      pad     = field_w - (digits.size() + (neg ? 1 : 0));
      if (pad < 0) pad = 0;

      if (ladj) begin
        if (neg) text.push_back(itpa_pkg::ASCII_MINUS);
        foreach (digits[i]) text.push_back(digits[i]);
        for (i = 0; i < pad; i++) text.push_back(itpa_pkg::ASCII_SPACE);
      end else begin
        pad_ch = zpad ? itpa_pkg::ASCII_ZERO : itpa_pkg::ASCII_SPACE;
        // zero fill goes after the sign, space fill before it
        if (neg && zpad) text.push_back(itpa_pkg::ASCII_MINUS);
        for (i = 0; i < pad; i++) text.push_back(pad_ch);
        if (neg && !zpad) text.push_back(itpa_pkg::ASCII_MINUS);
        foreach (digits[i]) text.push_back(digits[i]);
      end

      foreach (text[i]) begin
        fc.ch   = text[i];
        fc.last = (i == text.size() - 1);
        expected_chars.push_back(fc);
      end
    endfunction

    function void check_beat(input logic [itpa_pkg::CHAR_W-1:0] ch, input logic last);
      field_char_t fc;
      chars_seen++;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: char %h last %b", $time, ch, last);
        return;
      end
      fc = expected_chars.pop_front();
      if (ch !== fc.ch) begin
        errors++;
        $display("%0t: char mismatch: expected %h actual %h", $time, fc.ch, ch);
      end
      if (last !== fc.last) begin
        errors++;
        $display("%0t: last mismatch: expected %b actual %b", $time, fc.last, last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [itpa_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [itpa_pkg::CMD_W-1:0]      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [itpa_pkg::CHAR_W-1:0]     out_tdata;
  logic                            out_tlast;

  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  char_scoreboard board = new();

  integer_to_padded_ascii_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(input logic [itpa_pkg::CMD_W-1:0] cmd, input logic [31:0] value,
                           input logic [itpa_pkg::WIDTH_W-1:0] width, input logic ladj,
                           input logic zpad);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, zpad, ladj, width, value};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    board.note_item(cmd, value, width, ladj, zpad);
  endtask

  // Receiver: check each beat, insert random ready gaps and one long hold.
  initial begin : char_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready)
        board.check_beat(out_tdata, out_tlast);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end else if (hold_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 16);
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [itpa_pkg::CMD_W-1:0]   cmd;
    logic [31:0]                  value;
    logic [itpa_pkg::WIDTH_W-1:0] width;
    int                           n;
    int                           pick;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, sign and padding corners
    send_item(itpa_pkg::CMD_BIN,  32'h0000_0000, 7'd0,   1'b0, 1'b0);
    send_item(itpa_pkg::CMD_BIN,  32'hFFFF_FFFF, 7'd0,   1'b0, 1'b0);
    send_item(itpa_pkg::CMD_SDEC, 32'h8000_0000, 7'd0,   1'b0, 1'b0);
    send_item(itpa_pkg::CMD_SDEC, 32'hFFFF_FFFF, 7'd5,   1'b0, 1'b1);
    send_item(itpa_pkg::CMD_SDEC, 32'h7FFF_FFFF, 7'd0,   1'b0, 1'b0);
    send_item(itpa_pkg::CMD_SDEC, -32'sd42,      7'd8,   1'b1, 1'b1);
    send_item(itpa_pkg::CMD_SDEC, -32'sd42,      7'd8,   1'b0, 1'b0);
    send_item(itpa_pkg::CMD_OCT,  32'hFFFF_FFFF, 7'd0,   1'b0, 1'b0);
    send_item(itpa_pkg::CMD_OCT,  32'h0000_0008, 7'd6,   1'b0, 1'b1);
    send_item(itpa_pkg::CMD_UDEC, 32'hFFFF_FFFF, 7'd0,   1'b0, 1'b0);
    send_item(itpa_pkg::CMD_UDEC, 32'h8000_0000, 7'd64,  1'b0, 1'b1);
    send_item(itpa_pkg::CMD_HEXL, 32'hDEAD_BEEF, 7'd127, 1'b0, 1'b0);
    send_item(itpa_pkg::CMD_HEXU, 32'hDEAD_BEEF, 7'd65,  1'b1, 1'b0);
    send_item(itpa_pkg::CMD_HEXU, 32'h0000_0000, 7'd1,   1'b0, 1'b0);
    send_item(itpa_pkg::CMD_HEXL, 32'hABCD_EF01, 7'd3,   1'b0, 1'b1);
    send_item(3'd6,               32'h1234_5678, 7'd10,  1'b0, 1'b0);
    send_item(itpa_pkg::CMD_SDEC, 32'h0000_0000, 7'd64,  1'b1, 1'b0);
    send_item(itpa_pkg::CMD_BIN,  32'h0000_0005, 7'd70,  1'b0, 1'b1);
    send_item(itpa_pkg::CMD_SDEC, 32'h8000_0000, 7'd64,  1'b0, 1'b1);
    send_item(itpa_pkg::CMD_HEXL, 32'hFFFF_FFFF, 7'd64,  1'b1, 1'b1);
    send_item(itpa_pkg::CMD_SDEC, 32'd12345,     7'd2,   1'b0, 1'b0);
    send_item(3'd7,               32'hFFFF_FFFF, 7'd127, 1'b1, 1'b1);
    send_item(itpa_pkg::CMD_UDEC, 32'd9,         7'd12,  1'b1, 1'b0);

    // stall the receiver so the block backs up while items keep coming
    hold_request = 1'b1;

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;

      cmd = ($urandom_range(0, 19) == 0) ? itpa_pkg::CMD_W'($urandom_range(6, 7))
                                         : itpa_pkg::CMD_W'($urandom_range(0, 5));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        value = $urandom();
      end else if (pick < 60) begin
        value = $urandom_range(0, 99);
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0: value = 32'h0000_0000;
          1: value = 32'hFFFF_FFFF;
          2: value = 32'h8000_0000;
          default: value = 32'h7FFF_FFFF;
        endcase
      end else begin
        value = $urandom() >> $urandom_range(0, 31);
      end

      // mostly short fields; now and then full or saturating widths
      pick = $urandom_range(0, 99);
      if (pick < 60)      width = itpa_pkg::WIDTH_W'($urandom_range(0, 12));
      else if (pick < 85) width = itpa_pkg::WIDTH_W'($urandom_range(13, 64));
      else                width = itpa_pkg::WIDTH_W'($urandom_range(65, 127));

      send_item(cmd, value, width, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Formatted %0d fields (%0d ignored commands), %0d character beats checked.",
             board.fields, board.dropped, board.chars_seen);
    $display("Covered all six conversions, sign and padding corners, width saturation.");
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
